>>> rtl/bpfa_pkg.sv
// Shared constants, types and bitmap helper functions for the page frame allocator.
package bpfa_pkg;

    localparam int NUM_PAGES = 4096;
    localparam int ROW_BITS  = 64;
    localparam int ROW_SH    = $clog2(ROW_BITS);
    localparam int BYTE_BITS = 8;
    localparam int ROW_BYTES = ROW_BITS / BYTE_BITS;
    localparam int BYTE_SH   = $clog2(ROW_BYTES);
    localparam int BIT_SH    = $clog2(BYTE_BITS);
    localparam int NUM_ROWS  = (NUM_PAGES + ROW_BITS - 1) / ROW_BITS;
    localparam int ROW_W     = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;
    localparam int GRP_ROWS  = 8;
    localparam int GRP_SH    = $clog2(GRP_ROWS);
    localparam int NUM_GRPS  = (NUM_ROWS + GRP_ROWS - 1) / GRP_ROWS;
    localparam int GRP_W     = (NUM_GRPS > 1) ? $clog2(NUM_GRPS) : 1;
    localparam int LIMIT_W   = $clog2(NUM_PAGES + 1);
    localparam int TAIL      = NUM_PAGES % ROW_BITS;

    localparam int CMD_W  = 2;
    localparam int PAGE_W = 12;
    localparam int CFG_W  = 13;

    localparam logic [CFG_W-1:0]     RESERVED_RESET = CFG_W'(256);
    localparam logic [BYTE_BITS-1:0] FULL_BYTE      = 8'hFF;

    localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FREE  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_INIT  = 2'd2;

    // Bits past the last page in the final row always read as used
    localparam logic [ROW_BITS-1:0] OOB_LAST =
        (TAIL == 0) ? '0 : ~(({{(ROW_BITS-1){1'b0}}, 1'b1} << TAIL) - ROW_BITS'(1));

    typedef struct packed {
        logic load;
        logic grp_inc;
        logic scan_take;
        logic rd;
        logic pick;
        logic wr_alloc;
        logic wr_free;
        logic init;
        logic res_zero;
        logic res_none;
    } ctrl_t;

    typedef struct packed {
        logic in_range;
        logic grp_hit;
        logic grp_last;
    } stat_t;

    function automatic logic [ROW_BITS-1:0] row_oob(input logic [ROW_W-1:0] row);
        logic [ROW_BITS-1:0] res;
        res = (32'(row) == NUM_ROWS - 1) ? OOB_LAST : '0;
        return res;
    endfunction

    // Contents of a row not written since the last init: pages below limit are used
    function automatic logic [ROW_BITS-1:0] row_fill(input logic [ROW_W-1:0] row,
                                                     input logic [LIMIT_W-1:0] limit);
        logic [31:0]         lim_row;
        logic [ROW_SH-1:0]   lim_bit;
        logic [ROW_BITS-1:0] res;
        lim_row = 32'(limit) >> ROW_SH;
        lim_bit = ROW_SH'(32'(limit));
        if (32'(row) < lim_row)
            res = '1;
        else if (32'(row) == lim_row)
            res = ~({ROW_BITS{1'b1}} << lim_bit);
        else
            res = '0;
        return res;
    endfunction

endpackage

>>> rtl/bpfa_ctrl.sv
// Controller state machine sequencing allocate, free and init requests.
module bpfa_ctrl
    import bpfa_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [CMD_W-1:0] command,
    input  stat_t            stat,
    output ctrl_t            ctrl,
    output logic             busy,
    output logic             done
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_RD,
        ST_PICK,
        ST_AWR,
        ST_FWR
    } state_t;

    state_t state_reg, state_next;
    logic   done_reg, done_next;

    // Remember whether the running request is a free, to route the read stage
    logic command_is_free_reg, command_is_free_next;

    always_comb
    begin
        ctrl       = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    ctrl.load = 1'b1;
                    unique case (command)
                        CMD_ALLOC: state_next = ST_SCAN;
                        CMD_FREE:
                        begin
                            if (stat.in_range)
                                state_next = ST_RD;
                            else
                                ctrl.res_zero = 1'b1;
                        end
                        CMD_INIT:
                        begin
                            ctrl.init     = 1'b1;
                            ctrl.res_zero = 1'b1;
                        end
                        default: ctrl.res_zero = 1'b1;
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (stat.grp_hit)
                begin
                    ctrl.scan_take = 1'b1;
                    state_next     = ST_RD;
                end
                else if (stat.grp_last)
                begin
                    ctrl.res_none = 1'b1;
                    state_next    = ST_IDLE;
                end
                else
                    ctrl.grp_inc = 1'b1;
            end
            ST_RD:
            begin
                ctrl.rd    = 1'b1;
                state_next = (command_is_free_reg) ? ST_FWR : ST_PICK;
            end
            ST_PICK:
            begin
                ctrl.pick  = 1'b1;
                state_next = ST_AWR;
            end
            ST_AWR:
            begin
                ctrl.wr_alloc = 1'b1;
                state_next    = ST_IDLE;
            end
            ST_FWR:
            begin
                ctrl.wr_free = 1'b1;
                state_next   = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
        done_next = ctrl.res_zero | ctrl.res_none | ctrl.wr_alloc | ctrl.wr_free;
    end

    always_comb
    begin
        command_is_free_next = command_is_free_reg;
        if (ctrl.load)
            command_is_free_next = (command == CMD_FREE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg           <= ST_IDLE;
            done_reg            <= 1'b0;
            command_is_free_reg <= 1'b0;
        end
        else
        begin
            state_reg           <= state_next;
            done_reg            <= done_next;
            command_is_free_reg <= command_is_free_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = done_reg;

endmodule

>>> rtl/bpfa_dp.sv
// Datapath: bitmap row memory, row full flags, group scan and result registers.
module bpfa_dp
    import bpfa_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [PAGE_W-1:0] page_index,
    input  logic              cfg_we,
    input  logic [CFG_W-1:0]  reserved_pages,
    input  ctrl_t             ctrl,
    output stat_t             stat,
    output logic [PAGE_W-1:0] allocated_page,
    output logic              none_free
);

    logic [CFG_W-1:0]    reserved_reg;
    logic [LIMIT_W-1:0]  limit_reg;
    logic [LIMIT_W-1:0]  limit_sat;
    logic [NUM_ROWS-1:0] valid_reg;
    logic [NUM_ROWS-1:0] full_reg;
    logic [NUM_ROWS-1:0] init_full;
    logic [GRP_W-1:0]    grp_reg;
    logic [PAGE_W-1:0]   page_reg;
    logic                none_reg;

    logic [ROW_W-1:0]    row_reg;
    logic [ROW_SH-1:0]   pos_reg;
    logic [ROW_BITS-1:0] mem [NUM_ROWS];
    logic [ROW_BITS-1:0] q_reg;
    logic [ROW_BITS-1:0] word_reg;
    logic [BYTE_SH-1:0]  byte_reg;

    logic [NUM_GRPS*GRP_ROWS-1:0] full_pad;
    logic [GRP_ROWS-1:0]          grp_bits;
    logic [GRP_SH-1:0]            grp_lo;
    logic [ROW_W-1:0]             scan_row;
    logic [ROW_BITS-1:0]          eff;
    logic [BYTE_SH-1:0]           byte_lo;
    logic [BYTE_BITS-1:0]         sel_byte;
    logic [BIT_SH-1:0]            bit_lo;
    logic [ROW_SH-1:0]            pos;
    logic [ROW_BITS-1:0]          alloc_word;
    logic [ROW_BITS-1:0]          free_word;
    logic [PAGE_W-1:0]            alloc_page;

    assign limit_sat = (32'(reserved_reg) > 32'(NUM_PAGES)) ? LIMIT_W'(NUM_PAGES)
                                                             : LIMIT_W'(reserved_reg);

    always_comb
    begin
        for (int r = 0; r < NUM_ROWS; r++)
            init_full[r] = &(row_fill(ROW_W'(r), limit_sat) | row_oob(ROW_W'(r)));
    end

    // Scan eight row full flags per cycle; padding rows count as full
    always_comb
    begin
        full_pad                 = '1;
        full_pad[NUM_ROWS-1:0]   = full_reg;
        grp_bits = full_pad[32'(grp_reg) * GRP_ROWS +: GRP_ROWS];
        grp_lo   = '0;
        for (int i = GRP_ROWS - 1; i >= 0; i--)
            if (!grp_bits[i])
                grp_lo = GRP_SH'(i);
    end

    assign scan_row      = ROW_W'(32'(grp_reg) * GRP_ROWS + 32'(grp_lo));
    assign stat.grp_hit  = ~&grp_bits;
    assign stat.grp_last = (32'(grp_reg) == NUM_GRPS - 1);
    assign stat.in_range = (32'(page_index) < 32'(NUM_PAGES));

    // Unwritten rows take their contents from the limit of the last init
    assign eff = (valid_reg[row_reg] ? q_reg : row_fill(row_reg, limit_reg)) | row_oob(row_reg);

    always_comb
    begin
        byte_lo = '0;
        for (int i = ROW_BYTES - 1; i >= 0; i--)
            if (eff[i*BYTE_BITS +: BYTE_BITS] != FULL_BYTE)
                byte_lo = BYTE_SH'(i);
    end

    always_comb
    begin
        sel_byte = word_reg[32'(byte_reg) * BYTE_BITS +: BYTE_BITS];
        bit_lo   = '0;
        for (int i = BYTE_BITS - 1; i >= 0; i--)
            if (!sel_byte[i])
                bit_lo = BIT_SH'(i);
    end

    assign pos        = {byte_reg, bit_lo};
    assign alloc_word = word_reg | (ROW_BITS'(1) << pos);
    assign free_word  = eff & ~(ROW_BITS'(1) << pos_reg);
    assign alloc_page = PAGE_W'(32'(row_reg) * ROW_BITS + 32'(pos));

    always_ff @(posedge clk)
    begin
        if (ctrl.wr_alloc)
            mem[row_reg] <= alloc_word;
        else if (ctrl.wr_free)
            mem[row_reg] <= free_word;
        if (ctrl.rd)
            q_reg <= mem[row_reg];
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            row_reg <= ROW_W'(32'(page_index) >> ROW_SH);
            pos_reg <= ROW_SH'(32'(page_index));
        end
        else if (ctrl.scan_take)
            row_reg <= scan_row;
        if (ctrl.pick)
        begin
            word_reg <= eff;
            byte_reg <= byte_lo;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reserved_reg <= RESERVED_RESET;
            limit_reg    <= '0;
            valid_reg    <= '0;
            full_reg     <= '0;
            grp_reg      <= '0;
            page_reg     <= '0;
            none_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                reserved_reg <= reserved_pages;
            if (ctrl.load)
                grp_reg <= '0;
            else if (ctrl.grp_inc)
                grp_reg <= grp_reg + GRP_W'(1);
            if (ctrl.init)
            begin
                valid_reg <= '0;
                limit_reg <= limit_sat;
                full_reg  <= init_full;
            end
            if (ctrl.wr_alloc)
            begin
                valid_reg[row_reg] <= 1'b1;
                full_reg[row_reg]  <= &(alloc_word | row_oob(row_reg));
                page_reg           <= alloc_page;
                none_reg           <= 1'b0;
            end
            if (ctrl.wr_free)
            begin
                valid_reg[row_reg] <= 1'b1;
                full_reg[row_reg]  <= 1'b0;
                page_reg           <= '0;
                none_reg           <= 1'b0;
            end
            if (ctrl.res_zero)
            begin
                page_reg <= '0;
                none_reg <= 1'b0;
            end
            if (ctrl.res_none)
            begin
                page_reg <= '0;
                none_reg <= 1'b1;
            end
        end
    end

    assign allocated_page = page_reg;
    assign none_free      = none_reg;

endmodule

>>> rtl/bitmap_page_frame_allocator_top.sv
// Top level of the bitmap page frame allocator: controller plus datapath.
//
//  channel   signals                          handshake
//  -------   -------------------------------  ------------------------------
//  request   start, command, page_index       taken when start & !busy
//  result    done, allocated_page, none_free  done high for one cycle
//  config    cfg_we, reserved_pages           written when cfg_we is high
//
// Init and unused commands, and a free beyond the last page, finish without leaving idle.
// A free goes through a row read, then a write back.
// An allocate scans the row full flags 8 rows a cycle, then the chosen 64-bit
// row is read, searched and written back.
// After reset every page is free; the reserved count resets to 256.
// The receiver cannot stall; busy holds off the next request until done.
module bitmap_page_frame_allocator_top
    import bpfa_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [CMD_W-1:0]  command,
    input  logic [PAGE_W-1:0] page_index,
    output logic              done,
    output logic [PAGE_W-1:0] allocated_page,
    output logic              none_free,
    input  logic              cfg_we,
    input  logic [CFG_W-1:0]  reserved_pages
);

    ctrl_t ctrl;
    stat_t stat;

    bpfa_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .command (command),
        .stat    (stat),
        .ctrl    (ctrl),
        .busy    (busy),
        .done    (done)
    );

    bpfa_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .page_index     (page_index),
        .cfg_we         (cfg_we),
        .reserved_pages (reserved_pages),
        .ctrl           (ctrl),
        .stat           (stat),
        .allocated_page (allocated_page),
        .none_free      (none_free)
    );

endmodule
